@@ rtl/mepr_pkg.sv @@
package mepr_pkg;

   localparam int RADIUS_BITS = 10;
   localparam int COORD_BITS  = 12;
   localparam int OUT_BITS    = COORD_BITS + 1;
   localparam int POS_X_BITS  = RADIUS_BITS + 1;
   localparam int SQ_BITS     = 2 * RADIUS_BITS;
   localparam int MUL_BITS    = 2 * RADIUS_BITS + 3;
   localparam int PROD_BITS   = 2 * MUL_BITS;
   localparam int DEC_BITS    = 4 * RADIUS_BITS + 8;
   localparam int STEP_BITS   = 3 * RADIUS_BITS + 3;

   localparam int RX_LSB = 0;
   localparam int RY_LSB = RADIUS_BITS;
   localparam int CX_LSB = 2 * RADIUS_BITS;
   localparam int CY_LSB = 2 * RADIUS_BITS + COORD_BITS;
   localparam int REQ_DATA_BITS = ((2 * RADIUS_BITS + 2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((2 * OUT_BITS + 7) / 8) * 8;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_REG1 = 2'd1;
   localparam logic [1:0] PH_REG2 = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef struct packed {
      logic        [POS_X_BITS-1:0]  x;
      logic        [RADIUS_BITS-1:0] y;
      logic signed [COORD_BITS-1:0]  cx;
      logic signed [COORD_BITS-1:0]  cy;
   } point_set_type;

endpackage

@@ rtl/midpoint_ellipse_rasterizer_unit.sv @@
// Midpoint ellipse rasterizer. A start word (tuser 0) takes the radii and the centre, a step
// word (tuser 1) advances the outline by one iteration; each emitting word yields four mirrored
// points, the fourth with tlast, and tuser marks the points where y reached zero. A step on an
// idle or finished shape gives no point. The decision math runs on one shared 23 x 23 bit
// multiplier and a 48 bit decision register under a small sequencer. After an accepted word
// tready stays low while the sequencer works: through setup on a start, through the compare and
// the decision updates on a region one or region two step, and on the step that crosses into
// region two also through the exact recompute of the decision before the region two step; it
// then waits until a separate output stage is free, which sends one point per cycle while
// rsp_tready is high, so the next word is taken while the previous four points drain.
module midpoint_ellipse_rasterizer_unit import mepr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // radius_x, radius_y, center_x, center_y
   input  logic                     req_tuser,  // opcode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // pixel_x, pixel_y
   output logic                     rsp_tlast,  // last_of_item
   output logic                     rsp_tuser   // shape_done
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SETUP = 3'd1;
   localparam logic [2:0] S_R1    = 3'd2;
   localparam logic [2:0] S_CHG   = 3'd3;
   localparam logic [2:0] S_R2    = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic [1:0]                    phase_ff, phase_in;
   logic                          flag_ff, flag_in;
   logic [POS_X_BITS-1:0]         x_ff, x_in;
   logic [RADIUS_BITS-1:0]        y_ff, y_in;
   logic signed [DEC_BITS-1:0]    d_ff, d_in;
   logic signed [STEP_BITS-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_BITS-1:0]            a2_ff, a2_in, b2_ff, b2_in;
   logic signed [COORD_BITS-1:0]  cx_ff, cx_in, cy_ff, cy_in;

   logic [RADIUS_BITS-1:0]        rad_a, rad_b;
   logic [MUL_BITS-1:0]           op_a, op_b, tx, ty;
   logic [PROD_BITS-1:0]          p;
   logic signed [DEC_BITS-1:0]    p_dec, a2_dec, a2q_dec, b2_dec, dx_dec, dy_dec, d_bias;
   logic signed [STEP_BITS-1:0]   two_a2, two_b2, two_p;
   logic                          accept, emit_busy, emit_load;
   point_set_type                 emit_pts;

   assign rad_a  = req_tdata[RX_LSB +: RADIUS_BITS];
   assign rad_b  = req_tdata[RY_LSB +: RADIUS_BITS];
   assign accept = req_tvalid && req_tready;

   assign p_dec   = signed'(DEC_BITS'(p));
   assign a2_dec  = signed'(DEC_BITS'(a2_ff));
   assign a2q_dec = signed'(DEC_BITS'(a2_ff >> 2));
   assign b2_dec  = signed'(DEC_BITS'(b2_ff));
   assign dx_dec  = DEC_BITS'(dx_ff);
   assign dy_dec  = DEC_BITS'(dy_ff);
   assign two_a2  = signed'(STEP_BITS'({a2_ff, 1'b0}));
   assign two_b2  = signed'(STEP_BITS'({b2_ff, 1'b0}));
   assign two_p   = signed'(STEP_BITS'({p, 1'b0}));
   assign tx      = MUL_BITS'({x_ff, 1'b1});
   assign ty      = (y_ff == '0) ? MUL_BITS'(1) : MUL_BITS'(y_ff - 1'b1);
   // bias negative values so the shift truncates toward zero
   assign d_bias  = d_ff + signed'(DEC_BITS'({d_ff[DEC_BITS-1], d_ff[DEC_BITS-1]}));

   // operand select for the shared multiplier, the product is registered and back in the next cycle
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_IDLE: begin
            op_a = MUL_BITS'(rad_a);
            op_b = MUL_BITS'(rad_a);
         end
         S_SETUP: begin
            op_a = MUL_BITS'(y_ff);
            op_b = (cnt_ff == 3'd0) ? MUL_BITS'(y_ff) : MUL_BITS'(a2_ff);
         end
         S_CHG: begin
            case (cnt_ff)
               3'd0: begin
                  op_a = tx;
                  op_b = tx;
               end
               3'd1: begin
                  op_a = MUL_BITS'(p);
                  op_b = MUL_BITS'(b2_ff);
               end
               3'd2: begin
                  op_a = ty;
                  op_b = ty;
               end
               3'd3: begin
                  op_a = MUL_BITS'(p);
                  op_b = MUL_BITS'(a2_ff);
               end
               3'd4: begin
                  op_a = MUL_BITS'(a2_ff);
                  op_b = MUL_BITS'(b2_ff);
               end
               default: begin
                  op_a = '0;
                  op_b = '0;
               end
            endcase
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      flag_in  = flag_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      d_in     = d_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      a2_in    = a2_ff;
      b2_in    = b2_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      emit_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = 3'd0;
               if (req_tuser == OP_START) begin
                  cx_in    = req_tdata[CX_LSB +: COORD_BITS];
                  cy_in    = req_tdata[CY_LSB +: COORD_BITS];
                  x_in     = '0;
                  y_in     = rad_b;
                  dx_in    = '0;
                  state_in = S_SETUP;
               end else if (phase_ff == PH_REG1) begin
                  state_in = S_R1;
               end else if (phase_ff == PH_REG2) begin
                  state_in = S_R2;
               end
            end
         end
         S_SETUP: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd0: a2_in = SQ_BITS'(p);
               3'd1: b2_in = SQ_BITS'(p);
               default: begin
                  d_in     = b2_dec - p_dec + a2q_dec;
                  dy_in    = two_p;
                  phase_in = PH_REG1;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_R1: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd0: begin
                  if (dx_ff < dy_ff) begin
                     x_in    = x_ff + 1'b1;
                     dx_in   = dx_ff + two_b2;
                     flag_in = !d_ff[DEC_BITS-1];
                     if (!d_ff[DEC_BITS-1]) begin
                        y_in  = y_ff - 1'b1;
                        dy_in = dy_ff - two_a2;
                     end
                  end else begin
                     state_in = S_CHG;
                     cnt_in   = 3'd0;
                  end
               end
               3'd1: d_in = d_ff + b2_dec;
               3'd2: begin
                  d_in = d_ff + dx_dec;
                  if (!flag_ff) begin
                     state_in = S_EMIT;
                  end
               end
               default: begin
                  d_in     = d_ff - dy_dec;
                  state_in = S_EMIT;
               end
            endcase
         end
         S_CHG: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd2: d_in = p_dec;
               3'd4: d_in = d_ff + (p_dec <<< 2);
               3'd5: d_in = d_ff - (p_dec <<< 2);
               3'd6: begin
                  d_in     = d_bias >>> 2;
                  phase_in = PH_REG2;
                  state_in = S_R2;
                  cnt_in   = 3'd0;
               end
               default: d_in = d_ff;
            endcase
         end
         S_R2: begin
            cnt_in = cnt_ff + 3'd1;
            case (cnt_ff)
               3'd0: begin
                  if (y_ff == '0) begin
                     phase_in = PH_DONE;
                     state_in = S_IDLE;
                  end else begin
                     y_in    = y_ff - 1'b1;
                     dy_in   = dy_ff - two_a2;
                     flag_in = d_ff[DEC_BITS-1] || (d_ff == '0);
                     if (d_ff[DEC_BITS-1] || (d_ff == '0)) begin
                        x_in  = x_ff + 1'b1;
                        dx_in = dx_ff + two_b2;
                     end
                  end
               end
               3'd1: d_in = d_ff + a2_dec;
               3'd2: d_in = d_ff - dy_dec;
               default: begin
                  if (flag_ff) begin
                     d_in = d_ff + dx_dec;
                  end
                  state_in = S_EMIT;
               end
            endcase
         end
         S_EMIT: begin
            if (!emit_busy) begin
               emit_load = 1'b1;
               state_in  = S_IDLE;
               if (y_ff == '0) begin
                  phase_in = PH_DONE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= 3'd0;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         phase_ff <= phase_in;
      end
      flag_ff <= flag_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      d_ff    <= d_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      a2_ff   <= a2_in;
      b2_ff   <= b2_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
   end

   assign req_tready = (state_ff == S_IDLE);

   assign emit_pts.x  = x_ff;
   assign emit_pts.y  = y_ff;
   assign emit_pts.cx = cx_ff;
   assign emit_pts.cy = cy_ff;

   mepr_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (p)
   );

   mepr_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (emit_load),
      .load_pts   (emit_pts),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ rtl/mepr_mul.sv @@
module mepr_mul import mepr_pkg::*; (
   input  logic                 clock,
   input  logic [MUL_BITS-1:0]  op_a,
   input  logic [MUL_BITS-1:0]  op_b,
   output logic [PROD_BITS-1:0] product
);

   logic [PROD_BITS-1:0] product_ff;
   logic [PROD_BITS-1:0] product_in;

   assign product_in = PROD_BITS'(op_a) * PROD_BITS'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

@@ rtl/mepr_emit.sv @@
module mepr_emit import mepr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_valid,
   input  point_set_type            load_pts,
   output logic                     busy,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   output logic                     rsp_tuser
);

   logic          busy_ff, busy_in;
   logic [1:0]    k_ff, k_in;
   point_set_type pts_ff, pts_in;
   logic [OUT_BITS-1:0] cx_ext, cy_ext, x_ext, y_ext, px, py;

   always_comb begin
      busy_in = busy_ff;
      k_in    = k_ff;
      pts_in  = pts_ff;
      if (load_valid) begin
         busy_in = 1'b1;
         k_in    = 2'd0;
         pts_in  = load_pts;
      end else if (busy_ff && rsp_tready) begin
         k_in = k_ff + 2'd1;
         if (k_ff == 2'd3) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      pts_ff <= pts_in;
   end

   // mirror order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
   assign cx_ext = OUT_BITS'(pts_ff.cx);
   assign cy_ext = OUT_BITS'(pts_ff.cy);
   assign x_ext  = OUT_BITS'(pts_ff.x);
   assign y_ext  = OUT_BITS'(pts_ff.y);
   assign px     = k_ff[0] ? cx_ext - x_ext : cx_ext + x_ext;
   assign py     = k_ff[1] ? cy_ext - y_ext : cy_ext + y_ext;

   assign busy       = busy_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({py, px});
   assign rsp_tlast  = (k_ff == 2'd3);
   assign rsp_tuser  = (pts_ff.y == '0);

endmodule

@@ rtl/mepr_check.sv @@
module mepr_check import mepr_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic                     req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                     rsp_tlast,
   input logic                     rsp_tuser
);

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)
         && $stable(rsp_tuser))
      else $error("stalled output word changed");

   // the four points of one word follow without a gap and share shape_done
   a_group_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser)))
      else $error("point group broken or shape_done changed within group");

   // a start always keeps the sequencer busy for setup
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_START) |=> !req_tready)
      else $error("ready right after a start word");

   // no point straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind midpoint_ellipse_rasterizer_unit mepr_check u_mepr_check (.*);
